[src/sukt_pkg.sv]
// ----------------------------------------------------------------------------
// sukt_pkg
// Types, widths and codes shared by the sorted key table blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package sukt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths of the channels
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int ATTR_W   = 16;
  localparam int RD_W     = 6;
  localparam int STAT_W   = 2;
  localparam int OPOS_W   = 7;

  // reduction groups used when collecting the selected cell
  localparam int GRP_SIZE = 8;
  localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_READ   = 2'd2
  } cmd_code_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [KEY_W-1:0] part_key;
    logic                    part_kind;
    logic [ATTR_W-1:0]       part_attribute;
    logic [RD_W-1:0]         read_position;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [OPOS_W-1:0]       entry_position;
    logic signed [KEY_W-1:0] out_key;
    logic                    out_kind;
    logic [ATTR_W-1:0]       out_attribute;
    logic [OPOS_W-1:0]       entry_count;
  } rsp_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    kind;
    logic [ATTR_W-1:0]       attribute;
  } entry_t;

  typedef struct packed {
    logic take_left;
    logic take_new;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_GATHER,
    S_APPLY
  } state_t;

endpackage

`default_nettype wire

[src/sukt_if.sv]
// ----------------------------------------------------------------------------
// sukt_if
// Valid/ready channels for command and response beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface sukt_cmd_if import sukt_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sukt_rsp_if import sukt_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/sukt_cell.sv]
// ----------------------------------------------------------------------------
// sukt_cell
// One table slot: holds an entry, compares it against the probe key and
// takes either its left neighbor's entry or the new entry on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module sukt_cell import sukt_pkg::*; (
  input  wire logic                    clk,
  input  wire cell_ctrl_t              ctrl,
  input  wire entry_t                  left,
  input  wire entry_t                  fresh,
  input  wire logic signed [KEY_W-1:0] probe,
  output entry_t                       entry,
  output logic                         gt,
  output logic                         eq
);

  always_ff @(posedge clk) begin
    if (ctrl.take_left) begin
      entry <= left;
    end else if (ctrl.take_new) begin
      entry <= fresh;
    end
  end

  assign gt = entry.key > probe;
  assign eq = entry.key == probe;

endmodule

`default_nettype wire

[src/sorted_unique_key_table.sv]
// ----------------------------------------------------------------------------
// sorted_unique_key_table
// Sorted table of unique signed keys with insert, find and read commands.
// ----------------------------------------------------------------------------
// After its accepting beat each command passes through S_CMP, S_GATHER and
// S_APPLY: every cell compares its key with the probe key and the match and
// insert-position vectors are registered, the selected cell is collected
// through a registered tree of groups of eight cells, and in S_APPLY, once
// the response register is free, the response is loaded and, on insert, all
// cells above the insert point shift one place up at once. A new command is
// accepted the cycle after the response is loaded, so a command is taken
// only when the last one is done. The response register holds a finished
// beat while the next command is already in the compare stages. Table
// contents are undefined after reset; only the first entry_count positions
// are ever reported.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_key_table import sukt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  sukt_cmd_if.sink        cmd,
  sukt_rsp_if.source      rsp
);

  state_t state, state_next;

  cmd_t               cmd_q;
  logic [CNT_W-1:0]   fill_count;
  logic [CAPACITY-1:0] eq_q, gt_q;
  logic [CAPACITY-1:0] eq_v, gt_v, occ, sel, hit, gt_first;
  entry_t             entries [CAPACITY];
  cell_ctrl_t         ctrl    [CAPACITY];

  entry_t             grp_data [NUM_GRP];
  logic [IDX_W-1:0]   grp_pos  [NUM_GRP];
  logic [IDX_W-1:0]   grp_gpos [NUM_GRP];
  entry_t             grp_data_next [NUM_GRP];
  logic [IDX_W-1:0]   grp_pos_next  [NUM_GRP];
  logic [IDX_W-1:0]   grp_gpos_next [NUM_GRP];
  logic               any_sel;

  entry_t             fresh, hit_data;
  logic [IDX_W-1:0]   hit_pos, gt_pos;
  logic               any_eq, any_gt, full, do_ins, accept, load;
  rsp_t               rsp_next;
  logic               rsp_valid;
  rsp_t               rsp_data;

  localparam int SEL_W = IDX_W + RD_W;

  assign fresh = '{key: cmd_q.part_key, kind: cmd_q.part_kind,
                   attribute: cmd_q.part_attribute};

  // ---- cell row ----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_i;
    logic   gtl;

    if (i == 0) begin : g_first
      assign left_i = '0;
      assign gtl    = 1'b0;
    end else begin : g_rest
      assign left_i = entries[i-1];
      assign gtl    = gt_q[i-1];
    end

    assign occ[i] = CNT_W'(i) < fill_count;
    assign sel[i] = occ[i] && (SEL_W'(cmd_q.read_position) == SEL_W'(i));
    assign ctrl[i].take_left = do_ins && gtl;
    assign ctrl[i].take_new  = do_ins && !gtl &&
                               (gt_q[i] || (CNT_W'(i) == fill_count));

    sukt_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl[i]),
      .left  (left_i),
      .fresh (fresh),
      .probe (cmd_q.part_key),
      .entry (entries[i]),
      .gt    (gt_v[i]),
      .eq    (eq_v[i])
    );
  end

  // first greater entry marks the insert point (gt_q is a thermometer)
  assign gt_first = gt_q & ~{gt_q[CAPACITY-2:0], 1'b0};
  assign hit      = (cmd_q.command == CMD_READ) ? sel : eq_q;

  // ---- first level of the collection tree ----
  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_data_next[g] = '0;
      grp_pos_next[g]  = '0;
      grp_gpos_next[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (g * GRP_SIZE + j < CAPACITY) begin
          if (hit[g * GRP_SIZE + j]) begin
            grp_data_next[g] = grp_data_next[g] | entries[g * GRP_SIZE + j];
            grp_pos_next[g]  = grp_pos_next[g] | IDX_W'(g * GRP_SIZE + j);
          end
          if (gt_first[g * GRP_SIZE + j]) begin
            grp_gpos_next[g] = grp_gpos_next[g] | IDX_W'(g * GRP_SIZE + j);
          end
        end
      end
    end
  end

  // ---- second level ----
  always_comb begin
    hit_data = '0;
    hit_pos  = '0;
    gt_pos   = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      hit_data = hit_data | grp_data[g];
      hit_pos  = hit_pos | grp_pos[g];
      gt_pos   = gt_pos | grp_gpos[g];
    end
  end

  assign any_eq = |eq_q;
  assign any_gt = |gt_q;
  assign full   = fill_count == CNT_W'(CAPACITY);

  // ---- control ----
  assign accept = cmd.valid && cmd.ready;

  always_comb begin
    state_next = state;
    load       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_CMP;
      end
      S_CMP:    state_next = S_GATHER;
      S_GATHER: state_next = S_APPLY;
      S_APPLY: begin
        if (!rsp_valid || rsp.ready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign cmd.ready = (state == S_IDLE) && !rst;
  assign do_ins    = load && (cmd_q.command == CMD_INSERT) && !any_eq && !full;

  always_comb begin
    rsp_next = '0;
    rsp_next.entry_count = OPOS_W'(fill_count);
    case (cmd_q.command)
      CMD_INSERT: begin
        if (any_eq) begin
          rsp_next.status         = ST_DUP;
          rsp_next.entry_position = OPOS_W'(hit_pos);
          rsp_next.out_key        = hit_data.key;
          rsp_next.out_kind       = hit_data.kind;
          rsp_next.out_attribute  = hit_data.attribute;
        end else if (full) begin
          rsp_next.status         = ST_FULL;
          rsp_next.entry_position = OPOS_W'(fill_count);
        end else begin
          rsp_next.status         = ST_OK;
          rsp_next.entry_position = any_gt ? OPOS_W'(gt_pos) : OPOS_W'(fill_count);
          rsp_next.out_key        = fresh.key;
          rsp_next.out_kind       = fresh.kind;
          rsp_next.out_attribute  = fresh.attribute;
          rsp_next.entry_count    = OPOS_W'(fill_count + 1'b1);
        end
      end
      CMD_FIND: begin
        if (any_eq) begin
          rsp_next.status         = ST_OK;
          rsp_next.entry_position = OPOS_W'(hit_pos);
          rsp_next.out_key        = hit_data.key;
          rsp_next.out_kind       = hit_data.kind;
          rsp_next.out_attribute  = hit_data.attribute;
        end else begin
          rsp_next.status         = ST_MISS;
          rsp_next.entry_position = OPOS_W'(fill_count);
        end
      end
      CMD_READ: begin
        rsp_next.entry_position = OPOS_W'(cmd_q.read_position);
        if (any_sel) begin
          rsp_next.status         = ST_OK;
          rsp_next.out_key        = hit_data.key;
          rsp_next.out_kind       = hit_data.kind;
          rsp_next.out_attribute  = hit_data.attribute;
        end else begin
          rsp_next.status         = ST_MISS;
        end
      end
      default: begin
        rsp_next.status         = ST_MISS;
        rsp_next.entry_position = OPOS_W'(fill_count);
      end
    endcase
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (do_ins) fill_count <= fill_count + 1'b1;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cmd_q <= cmd.data;
    if (state == S_CMP) begin
      eq_q <= eq_v & occ;
      gt_q <= gt_v & occ;
    end
    if (state == S_GATHER) begin
      grp_data <= grp_data_next;
      grp_pos  <= grp_pos_next;
      grp_gpos <= grp_gpos_next;
      any_sel  <= |sel;
    end
    if (load) rsp_data <= rsp_next;
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // ---- assertions ----
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_unique_keys: assert property (@(posedge clk) disable iff (rst)
    state == S_GATHER |-> $onehot0(eq_q))
    else $error("more than one stored entry matches the probe key");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    fill_count != $past(fill_count) |->
      fill_count == CNT_W'($past(fill_count) + 1'b1))
    else $error("fill count changed by other than one");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_CMP)
    else $error("accepted command did not enter compare");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    load |=> rsp_valid && state == S_IDLE)
    else $error("response load did not finish the command");

endmodule

`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted unique key table.
// ----------------------------------------------------------------------------
// A short scripted list of commands runs on an empty table first: misses,
// the key extremes, duplicates, out-of-range reads and the unused opcode.
// Random traffic follows. It partly fills the table, fills it to capacity, and
// then hammers the full table. The bench keeps its own sorted copy of the
// table to predict each response beat. Both channels stall in random bursts
// except in the final stretch.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sukt_pkg::*;

  localparam logic [CMD_W-1:0]        CMD_UNUSED   = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN      = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX      = 32'sh7FFF_FFFF;
  localparam int unsigned             RUN_LIMIT_NS = 2_000_000;

  typedef struct {
    cmd_t beat;
    bit   typed;
    rsp_t reply;
  } script_row_t;

  logic clk;
  logic rst;

  sukt_cmd_if cmd_ch();
  sukt_rsp_if rsp_ch();

  sorted_unique_key_table dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // bench copy of the table, kept sorted by signed key
  entry_t      held_entries[CAPACITY];
  int          held_count = 0;
  rsp_t        pending_rsp[$];
  script_row_t script_rows[$];
  int          fail_count = 0;
  bit          src_idle_on = 1'b1;
  bit          sink_stall_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  function automatic rsp_t table_reply(status_t st, int pos, bit with_entry);
    rsp_t r;
    r = '0;
    r.status = st;
    r.entry_position = pos[OPOS_W-1:0];
    if (with_entry) begin
      r.out_key       = held_entries[pos].key;
      r.out_kind      = held_entries[pos].kind;
      r.out_attribute = held_entries[pos].attribute;
    end
    r.entry_count = held_count[OPOS_W-1:0];
    return r;
  endfunction

  // Runs one command against the bench table and returns its response.
  function automatic rsp_t apply_table_cmd(cmd_t c);
    rsp_t r;
    int   pos;
    bit   hit;
    hit = 1'b0;
    // pos ends on the match, or on the first larger key
    for (pos = 0; pos < held_count; pos++) begin
      if (held_entries[pos].key == c.part_key) begin
        hit = 1'b1;
        break;
      end
      if ($signed(held_entries[pos].key) > $signed(c.part_key)) break;
    end
    case (c.command)
      CMD_INSERT: begin
        if (hit) begin
          r = table_reply(ST_DUP, pos, 1'b1);
        end else if (held_count >= CAPACITY) begin
          r = table_reply(ST_FULL, held_count, 1'b0);
        end else begin
          for (int i = held_count; i > pos; i--) held_entries[i] = held_entries[i-1];
          held_entries[pos].key       = c.part_key;
          held_entries[pos].kind      = c.part_kind;
          held_entries[pos].attribute = c.part_attribute;
          held_count++;
          r = table_reply(ST_OK, pos, 1'b1);
        end
      end
      CMD_FIND: begin
        if (hit) r = table_reply(ST_OK, pos, 1'b1);
        else r = table_reply(ST_MISS, held_count, 1'b0);
      end
      CMD_READ: begin
        if (int'(c.read_position) < held_count)
          r = table_reply(ST_OK, int'(c.read_position), 1'b1);
        else r = table_reply(ST_MISS, int'(c.read_position), 1'b0);
      end
      default: begin
        r = table_reply(ST_MISS, held_count, 1'b0);
      end
    endcase
    return r;
  endfunction

  function automatic cmd_t mk_cmd(logic [CMD_W-1:0] op, logic signed [KEY_W-1:0] key,
                                  bit kind, int attr, int rpos);
    cmd_t c;
    c.command        = op;
    c.part_key       = key;
    c.part_kind      = kind;
    c.part_attribute = attr[ATTR_W-1:0];
    c.read_position  = rpos[RD_W-1:0];
    return c;
  endfunction

  function automatic rsp_t mk_rsp(status_t st, int pos, logic signed [KEY_W-1:0] key,
                                  bit kind, int attr, int cnt);
    rsp_t r;
    r.status         = st;
    r.entry_position = pos[OPOS_W-1:0];
    r.out_key        = key;
    r.out_kind       = kind;
    r.out_attribute  = attr[ATTR_W-1:0];
    r.entry_count    = cnt[OPOS_W-1:0];
    return r;
  endfunction

  function automatic void add_row(cmd_t beat, bit typed, rsp_t reply);
    script_row_t row;
    row.beat  = beat;
    row.typed = typed;
    row.reply = reply;
    script_rows.push_back(row);
  endfunction

  // Biased toward keys already held, their neighbors and the extremes.
  function automatic logic signed [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 9);
    if (held_count > 0 && roll < 4) return held_entries[$urandom_range(0, held_count - 1)].key;
    if (held_count > 0 && roll == 4)
      return held_entries[$urandom_range(0, held_count - 1)].key + ($urandom_range(0, 1) ? 1 : -1);
    if (roll == 5) begin
      case ($urandom_range(0, 4))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic cmd_t random_cmd(int insert_pct);
    cmd_t c;
    int   roll;
    int   top;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) c.command = CMD_INSERT;
    else if (roll < 95) c.command = $urandom_range(0, 1) ? CMD_FIND : CMD_READ;
    else c.command = CMD_UNUSED;
    c.part_key       = pick_key();
    c.part_kind      = 1'($urandom_range(0, 1));
    c.part_attribute = ATTR_W'($urandom_range(0, 16'hFFFF));
    top = (held_count > 63) ? 63 : held_count;
    c.read_position  = ($urandom_range(0, 3) == 0) ? RD_W'($urandom_range(0, 63)) :
                                                     RD_W'($urandom_range(0, top));
    return c;
  endfunction

  // Entered and left right after a falling edge.
  task automatic send_cmd(cmd_t beat, bit typed, rsp_t typed_reply);
    rsp_t predicted;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= beat;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    predicted = apply_table_cmd(beat);
    pending_rsp.push_back(typed ? typed_reply : predicted);
    @(negedge clk);
  endtask

  task automatic drain_responses();
    cmd_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_phase(int count, int insert_pct, bit vary_idle);
    for (int i = 0; i < count; i++) begin
      if (vary_idle && i % 40 == 0) begin
        src_idle_on   = ($urandom_range(0, 2) != 0);
        sink_stall_on = ($urandom_range(0, 2) != 0);
      end
      send_cmd(random_cmd(insert_pct), 1'b0, '0);
    end
  endtask

  function automatic void compare_field(string fname, logic [KEY_W-1:0] want,
                                        logic [KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      fail_count++;
    end
  endfunction

  // response sink: ready drops in random bursts
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_stall_on && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t ns: response beat with nothing expected, actual %h", $time, rsp_ch.data);
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        compare_field("status", want.status, rsp_ch.data.status);
        compare_field("entry_position", want.entry_position, rsp_ch.data.entry_position);
        compare_field("out_key", want.out_key, rsp_ch.data.out_key);
        compare_field("out_kind", want.out_kind, rsp_ch.data.out_kind);
        compare_field("out_attribute", want.out_attribute, rsp_ch.data.out_attribute);
        compare_field("entry_count", want.entry_count, rsp_ch.data.entry_count);
      end
    end
  end

  initial begin
    rst          = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;

    // empty table
    add_row(mk_cmd(CMD_FIND, 0, 0, 0, 0), 1, mk_rsp(ST_MISS, 0, 0, 0, 0, 0));
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0), 1, mk_rsp(ST_MISS, 0, 0, 0, 0, 0));
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 63), 1, mk_rsp(ST_MISS, 63, 0, 0, 0, 0));
    add_row(mk_cmd(CMD_UNUSED, KEY_MAX, 1, 16'hFFFF, 63), 1, mk_rsp(ST_MISS, 0, 0, 0, 0, 0));
    // extremes, then a key landing between them
    add_row(mk_cmd(CMD_INSERT, KEY_MIN, 0, 0, 0), 1, mk_rsp(ST_OK, 0, KEY_MIN, 0, 0, 1));
    add_row(mk_cmd(CMD_INSERT, KEY_MAX, 1, 16'hFFFF, 63), 1,
            mk_rsp(ST_OK, 1, KEY_MAX, 1, 16'hFFFF, 2));
    add_row(mk_cmd(CMD_INSERT, 0, 1, 16'h1234, 0), 1, mk_rsp(ST_OK, 1, 0, 1, 16'h1234, 3));
    // duplicates report the stored entry, not the new data
    add_row(mk_cmd(CMD_INSERT, KEY_MIN, 1, 16'h5555, 0), 1, mk_rsp(ST_DUP, 0, KEY_MIN, 0, 0, 3));
    add_row(mk_cmd(CMD_INSERT, KEY_MAX, 0, 0, 0), 1,
            mk_rsp(ST_DUP, 2, KEY_MAX, 1, 16'hFFFF, 3));
    add_row(mk_cmd(CMD_FIND, KEY_MAX, 0, 0, 0), 1, mk_rsp(ST_OK, 2, KEY_MAX, 1, 16'hFFFF, 3));
    add_row(mk_cmd(CMD_FIND, -1, 1, 16'hFFFF, 63), 1, mk_rsp(ST_MISS, 3, 0, 0, 0, 3));
    add_row(mk_cmd(CMD_READ, KEY_MAX, 1, 16'hFFFF, 0), 1, mk_rsp(ST_OK, 0, KEY_MIN, 0, 0, 3));
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 2), 1, mk_rsp(ST_OK, 2, KEY_MAX, 1, 16'hFFFF, 3));
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 3), 1, mk_rsp(ST_MISS, 3, 0, 0, 0, 3));
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 63), 1, mk_rsp(ST_MISS, 63, 0, 0, 0, 3));
    add_row(mk_cmd(CMD_UNUSED, 0, 1, 16'hAAAA, 21), 1, mk_rsp(ST_MISS, 3, 0, 0, 0, 3));
    add_row(mk_cmd(CMD_INSERT, -1, 0, 16'hAAAA, 0), 0, '0);
    add_row(mk_cmd(CMD_INSERT, 1, 1, 16'h5555, 0), 0, '0);
    add_row(mk_cmd(CMD_INSERT, KEY_MAX - 1, 0, 16'h8001, 0), 0, '0);
    add_row(mk_cmd(CMD_INSERT, KEY_MIN + 1, 1, 16'h7FFE, 0), 0, '0);
    add_row(mk_cmd(CMD_FIND, 0, 0, 0, 0), 0, '0);
    add_row(mk_cmd(CMD_FIND, KEY_MIN, 0, 0, 0), 0, '0);
    add_row(mk_cmd(CMD_FIND, 2, 0, 0, 0), 0, '0);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 6), 0, '0);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 7), 0, '0);

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    foreach (script_rows[k]) send_cmd(script_rows[k].beat, script_rows[k].typed,
                                      script_rows[k].reply);
    drain_responses();

    // partly filled table, mostly lookups
    random_phase(300, 20, 1'b1);
    drain_responses();

    // insert until full; duplicates still show up along the way
    while (held_count < CAPACITY) send_cmd(random_cmd(100), 1'b0, '0);
    drain_responses();

    // full table: duplicate check ahead of the full status
    random_phase(250, 35, 1'b1);

    src_idle_on   = 1'b0;
    sink_stall_on = 1'b0;
    random_phase(150, 30, 1'b0);

    drain_responses();
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/sukt_pkg.sv
src/sukt_if.sv
src/sukt_cell.sv
src/sorted_unique_key_table.sv
verif/tb_top.sv
